// ===== sv/dhrt_pkg.sv =====
// shared types, codes and constants of the double hash record table
package dhrt_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam logic [10:0] RESET_TABLE_SIZE = 11'd1021;
    localparam logic [9:0]  RESET_STEP_PRIME = 10'd1019;
    localparam logic [8:0]  SCORE_LIMIT      = 9'd24;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_ADD    = 2'd1,
        FN_EMAIL  = 2'd2,
        FN_LOOKUP = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EXCEEDED  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_STEP_PRIME = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [30:0] key;
        logic [63:0] email;
        logic [7:0]  credits;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] probes;
        logic [4:0]  score;
        logic [63:0] email_out;
        logic [10:0] occupancy;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SDIV,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic sdiv_step;
        logic rd;
        logic advance;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic sdiv_last;
        logic key_zero;
        logic stop;
        logic limit;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/dhrt_ram.sv =====
// generic single write port ram with registered read
module dhrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dhrt_ctrl.sv =====
// sequencer for clear, hash division, probing and result hand-off
module dhrt_ctrl
    import dhrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.key_zero) n_state = S_FINISH;
                else if (i_sts.div_last) n_state = S_SDIV;
            end
            S_SDIV: begin
                if (i_sts.sdiv_last) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.stop || i_sts.limit) n_state = S_FINISH;
                else n_state = S_READ;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DIV:   o_cmd.div_step  = !i_sts.key_zero;
            S_SDIV:  o_cmd.sdiv_step = 1'b1;
            S_READ:  o_cmd.rd        = 1'b1;
            S_CHECK: o_cmd.advance   = !(i_sts.stop || i_sts.limit);
            S_FINISH: o_cmd.commit   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_load_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DIV)
        else $error("load did not start division");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit with output register full");
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == S_IDLE)
        else $error("commit not followed by idle");

endmodule

// ===== sv/dhrt_dpath.sv =====
// datapath: config, remainder units, probe walk, slot stores and result register
module dhrt_dpath
    import dhrt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_data,
    input  t_in_item    i_in,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (AW > 11) ? AW + 1 : 12;

    logic [10:0] r_table_size;
    logic [9:0]  r_step_prime;
    t_in_item    r_item;
    logic [4:0]  r_bit;
    logic [10:0] r_rem_n;
    logic [9:0]  r_rem_q;
    logic [9:0]  r_sdiv;
    logic [9:0]  r_srem;
    logic [AW-1:0] r_idx;
    logic [10:0] r_pcnt;
    logic [10:0] r_fill;
    logic [AW-1:0] r_clr;
    logic        r_ovalid;
    t_out_item   r_out;

    logic [10:0] n_sz;
    logic [9:0]  q_pr;
    logic [11:0] tn;
    logic [10:0] tq;
    logic [10:0] ts;
    logic [10:0] n_rem_n;
    logic [9:0]  n_rem_q;
    logic [9:0]  n_srem;
    logic [PW-1:0] nxt_sum;
    logic [AW-1:0] n_idx;
    logic [35:0] rd_key;
    logic [63:0] rd_mail;
    logic [30:0] rk;
    logic [4:0]  rs;
    logic [8:0]  add_sum;
    logic        stop;
    logic        kwe;
    logic        mwe;
    logic [35:0] kwdata;
    logic [AW-1:0] waddr;
    t_out_item   res;
    logic        fill_inc;

    // effective table size and step modulus
    always_comb begin
        if (r_table_size == 11'd0) n_sz = 11'd1;
        else if ({21'd0, r_table_size} > 32'(CAPACITY)) n_sz = 11'(CAPACITY);
        else n_sz = r_table_size;
        q_pr = (r_step_prime == 10'd0) ? 10'd1 : r_step_prime;
    end

    // one quotient bit per cycle for both hashes, then the step reduced by size
    always_comb begin
        tn = {r_rem_n, r_item.key[r_bit]};
        n_rem_n = (tn >= {1'b0, n_sz}) ? 11'(tn - {1'b0, n_sz}) : tn[10:0];
        tq = {r_rem_q, r_item.key[r_bit]};
        n_rem_q = (tq >= {1'b0, q_pr}) ? 10'(tq - {1'b0, q_pr}) : tq[9:0];
        ts = {r_srem, r_sdiv[r_bit[3:0]]};
        n_srem = (ts >= n_sz) ? 10'(ts - n_sz) : ts[9:0];
        nxt_sum = PW'(r_idx) + PW'(r_srem);
        n_idx = (nxt_sum >= PW'(n_sz)) ? AW'(nxt_sum - PW'(n_sz)) : AW'(nxt_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= RESET_TABLE_SIZE;
            r_step_prime <= RESET_STEP_PRIME;
            r_fill       <= '0;
            r_clr        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TABLE_SIZE) r_table_size <= i_cfg_data;
                if (i_cfg_addr == CFG_STEP_PRIME) r_step_prime <= i_cfg_data[9:0];
            end
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (fill_inc) r_fill <= r_fill + 11'd1;
            if (i_cmd.commit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in;
            r_bit   <= 5'd30;
            r_rem_n <= '0;
            r_rem_q <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_n <= n_rem_n;
            r_rem_q <= n_rem_q;
            r_bit   <= r_bit - 5'd1;
            if (r_bit == 5'd0) begin
                r_sdiv <= q_pr - n_rem_q;
                r_srem <= '0;
                r_bit  <= 5'd9;
            end
        end
        if (i_cmd.sdiv_step) begin
            r_srem <= n_srem;
            r_bit  <= r_bit - 5'd1;
            if (r_bit == 5'd0) begin
                r_idx  <= AW'(r_rem_n);
                r_pcnt <= 11'd1;
            end
        end
        if (i_cmd.advance) begin
            r_idx  <= n_idx;
            r_pcnt <= r_pcnt + 11'd1;
        end
        if (i_cmd.commit) r_out <= res;
    end

    // key and score share one cleared store, emails are written before read
    always_comb begin
        rk = rd_key[35:5];
        rs = rd_key[4:0];
        add_sum = {4'd0, rs} + {1'b0, r_item.credits};
        if (r_item.func == FN_INSERT) stop = (rk == 31'd0);
        else stop = (rk == r_item.key) || (rk == 31'd0);

        res = '0;
        res.status = ST_NOT_FOUND;
        res.probes = r_pcnt;
        kwe = 1'b0;
        mwe = 1'b0;
        kwdata = '0;
        fill_inc = 1'b0;
        if (r_item.key == 31'd0) begin
            res.probes = 11'd1;
        end else if (r_item.func == FN_INSERT) begin
            if (stop) begin
                res.status    = ST_OK;
                res.email_out = r_item.email;
                kwdata        = {r_item.key, 5'd0};
                kwe           = 1'b1;
                mwe           = 1'b1;
                fill_inc      = 1'b1;
            end else begin
                res.status = ST_FULL;
            end
        end else if (rk == r_item.key) begin
            res.status    = ST_OK;
            res.score     = rs;
            res.email_out = rd_mail;
            case (r_item.func)
                FN_ADD: begin
                    if (add_sum > SCORE_LIMIT) begin
                        res.status = ST_EXCEEDED;
                    end else begin
                        res.score = add_sum[4:0];
                        kwdata    = {rk, add_sum[4:0]};
                        kwe       = 1'b1;
                    end
                end
                FN_EMAIL: begin
                    res.email_out = r_item.email;
                    mwe           = 1'b1;
                end
                default: begin
                    res.status = ST_OK;
                end
            endcase
        end
        res.occupancy = fill_inc ? r_fill + 11'd1 : r_fill;
        kwe      = (kwe && i_cmd.commit) || i_cmd.clr_step;
        mwe      = mwe && i_cmd.commit;
        fill_inc = fill_inc && i_cmd.commit;
        if (i_cmd.clr_step) kwdata = '0;
        waddr = i_cmd.clr_step ? r_clr : r_idx;
    end

    dhrt_ram #(.WIDTH(36), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (kwe),
        .i_waddr (waddr),
        .i_wdata (kwdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_key)
    );

    dhrt_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_mail_ram (
        .i_clk   (i_clk),
        .i_we    (mwe),
        .i_waddr (r_idx),
        .i_wdata (r_item.email),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_mail)
    );

    always_comb begin
        o_sts.clr_last  = (r_clr == AW'(CAPACITY - 1));
        o_sts.div_last  = (r_bit == 5'd0);
        o_sts.sdiv_last = (r_bit == 5'd0);
        o_sts.key_zero  = (r_item.key == 31'd0);
        o_sts.stop      = stop;
        o_sts.limit     = (r_pcnt == n_sz);
        o_sts.out_free  = !r_ovalid || i_ready;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> {{(32 - AW){1'b0}}, r_idx} < {21'd0, n_sz})
        else $error("probe slot outside table");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {21'd0, r_fill} <= 32'(CAPACITY))
        else $error("occupancy above capacity");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> r_pcnt < n_sz)
        else $error("probe walk past table size");

endmodule

// ===== sv/double_hash_record_table.sv =====
// top level of the double hash record table
//
//  port group      dir   handshake           payload
//  input item      in    i_valid / o_ready   i_in  (t_in_item)
//  result item     out   o_valid / i_ready   o_out (t_out_item)
//  configuration   in    i_cfg_we            i_cfg_addr, i_cfg_data
//
//  an item is loaded, divided for both hashes, its step reduced by the size,
//  then walked with a slot read and a check per probe before the hand-off:
//  the shared one-bit-a-cycle remainder units and the one-read-port slot
//  store with registered read set this; a key of zero goes straight to the hand-off
//  after reset a clearing pass empties the key store,
//  o_ready stays low meanwhile; config writes are taken at any time
//  a result waits in the output register; the next item is accepted,
//  and only its hand-off waits for i_ready
module double_hash_record_table
    import dhrt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item in
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_in,
    // item out
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_out,
    // register writes, index 0 table size, index 1 step prime
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_data
);

    // command and status bundles between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clear, divide, probe, hand off
    dhrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hashes, slot stores and output register
    dhrt_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule

// ===== dv/double_hash_record_table_tb.sv =====
// self-checking testbench of the double hash record table
module double_hash_record_table_tb;
    import dhrt_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int STALL_MAX  = 7;
    // longest silent stretch: clearing pass or a full-length probe walk
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_in;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [10:0] i_cfg_data;

    double_hash_record_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the table and its registers
    logic [30:0] tbl_key   [SLOTS];
    logic [4:0]  tbl_score [SLOTS];
    logic [63:0] tbl_email [SLOTS];
    int unsigned tbl_fill;
    logic [10:0] reg_size;
    logic [9:0]  reg_step;

    t_out_item   pending_results[$];
    logic [30:0] known_keys[$];
    int          mismatches;
    int          idle_cycles;
    int          send_gap;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // one table operation on the shadow copy, returns the expected result item
    function automatic t_out_item table_op(t_in_item it);
        t_out_item   r;
        int unsigned n, q, idx, stp, p, slot;
        bit          met, hit;
        logic [30:0] k;
        r = '0;
        r.status = ST_NOT_FOUND;
        r.probes = 11'd1;
        n = (reg_size == 0) ? 1 : (reg_size > SLOTS) ? SLOTS : reg_size;
        q = (reg_step == 0) ? 1 : reg_step;
        if (it.key != 0) begin
            idx = it.key % n;
            stp = q - (it.key % q);
            met = 1'b0;
            hit = 1'b0;
            slot = 0;
            r.probes = 11'(n);
            for (p = 1; p <= n && !met; p++) begin
                k = tbl_key[idx];
                if (k == 0 || (it.func != FN_INSERT && k == it.key)) begin
                    met = 1'b1;
                    hit = (k == it.key);
                    slot = idx;
                    r.probes = 11'(p);
                end else begin
                    idx = (idx + stp) % n;
                end
            end
            if (it.func == FN_INSERT) begin
                if (met) begin
                    tbl_key[slot]   = it.key;
                    tbl_score[slot] = '0;
                    tbl_email[slot] = it.email;
                    tbl_fill++;
                    r.status    = ST_OK;
                    r.email_out = it.email;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (hit) begin
                r.status = ST_OK;
                if (it.func == FN_ADD) begin
                    if (tbl_score[slot] + it.credits > SCORE_LIMIT)
                        r.status = ST_EXCEEDED;
                    else
                        tbl_score[slot] = tbl_score[slot] + it.credits;
                end else if (it.func == FN_EMAIL) begin
                    tbl_email[slot] = it.email;
                end
                r.score     = tbl_score[slot];
                r.email_out = tbl_email[slot];
            end
        end
        r.occupancy = 11'(tbl_fill);
        return r;
    endfunction

    // one item into the block; valid stays high when the next item follows at once
    task automatic send_item(t_in_item it);
        if (send_gap > 0) begin
            i_valid <= 1'b0;
            repeat (send_gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(table_op(it));
        if (it.func == FN_INSERT && it.key != 0) known_keys.push_back(it.key);
        if (known_keys.size() > 64) void'(known_keys.pop_front());
        send_gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    endtask

    task automatic send_op(t_func f, logic [30:0] key, logic [63:0] mail, logic [7:0] cr);
        t_in_item it;
        it.func    = f;
        it.key     = key;
        it.email   = mail;
        it.credits = cr;
        send_item(it);
    endtask

    // sender holds off until every expected result is back
    task automatic drain;
        i_valid <= 1'b0;
        send_gap = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic addr, logic [10:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (addr == CFG_TABLE_SIZE) reg_size = data;
        else                        reg_step = data[9:0];
    endtask

    task automatic set_geometry(logic [10:0] size, logic [10:0] step);
        drain();
        cfg_write(CFG_TABLE_SIZE, size);
        cfg_write(CFG_STEP_PRIME, step);
        i_cfg_we <= 1'b0;
    endtask

    // empty table and the key that names no record
    task automatic test_empty_and_zero_key;
        send_op(FN_LOOKUP, 31'd5, '0, '0);
        send_op(FN_INSERT, 31'd0, '1, 8'd3);
        send_op(FN_ADD,    31'd0, '0, 8'd1);
        send_op(FN_EMAIL,  31'd0, '1, '0);
        send_op(FN_LOOKUP, 31'd0, '0, '0);
    endtask

    // insert, credit limit, email change and lookup on the reset geometry
    task automatic test_record_ops;
        send_op(FN_INSERT, 31'h7fffffff, '1, 8'hff);
        send_op(FN_INSERT, 31'd1, '0, '0);
        send_op(FN_ADD,    31'd1, '0, 8'd24);
        send_op(FN_ADD,    31'd1, '0, 8'd1);
        send_op(FN_ADD,    31'd1, '0, 8'd0);
        send_op(FN_ADD,    31'h7fffffff, '0, 8'd255);
        send_op(FN_ADD,    31'h7fffffff, '0, 8'd7);
        send_op(FN_EMAIL,  31'h7fffffff, 64'h0123_4567_89ab_cdef, '0);
        send_op(FN_EMAIL,  31'd1, '1, '0);
        send_op(FN_LOOKUP, 31'h7fffffff, '0, '0);
        send_op(FN_LOOKUP, 31'd1022, '0, '0);
    endtask

    // colliding keys on a tiny table until it is full, then probe limit
    task automatic test_collisions_and_full;
        set_geometry(11'd5, 11'd3);
        for (int i = 1; i <= 6; i++) send_op(FN_INSERT, 31'(i * 5), 64'(i), '0);
        send_op(FN_LOOKUP, 31'd10, '0, '0);
        send_op(FN_LOOKUP, 31'd999, '0, '0);
        send_op(FN_ADD,    31'd999, '0, 8'd1);
    endtask

    // register extremes: zero acts as one, oversize acts as capacity
    task automatic test_size_extremes;
        set_geometry(11'd0, 11'd0);
        send_op(FN_INSERT, 31'd77, 64'hdead_beef, '0);
        send_op(FN_LOOKUP, 31'd78, '0, '0);
        set_geometry(11'd2047, 11'd1023);
        send_op(FN_INSERT, 31'd2047, 64'h5a5a, '0);
        send_op(FN_LOOKUP, 31'd2047, '0, '0);
        set_geometry(11'd1024, 11'd1);
        send_op(FN_INSERT, 31'd3071, 64'ha5a5, '0);
        send_op(FN_ADD,    31'd3071, '0, 8'd12);
    endtask

    // random traffic, mostly on keys already stored
    task automatic test_random_traffic(int count);
        t_in_item it;
        int       sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            it.func = (sel < 30) ? FN_INSERT : t_func'($urandom_range(1, 3));
            sel = $urandom_range(0, 99);
            if (sel < 65 && known_keys.size() != 0)
                it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if (sel < 90)
                it.key = 31'($urandom_range(1, 5000));
            else
                it.key = 31'($urandom);
            it.email   = {$urandom, $urandom};
            it.credits = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 12))
                                                    : 8'($urandom_range(0, 255));
            send_item(it);
            // sender pauses mid-phase until the block has drained
            if (i == count / 2) drain();
        end
    endtask

    task automatic test_random_geometries;
        logic [10:0] sizes [7] = '{11'd1021, 11'd13, 11'd1024, 11'd97, 11'd2, 11'd1, 11'd0};
        logic [10:0] steps [7] = '{11'd1019, 11'd11, 11'd1023, 11'd89, 11'd1, 11'd0, 11'd7};
        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph % 4 == 3);
            if (ph < 7) set_geometry(sizes[ph], steps[ph]);
            else        set_geometry(11'($urandom_range(0, 2047)),
                                     11'($urandom_range(0, 1023)));
            test_random_traffic(112);
        end
        calm = 1'b0;
    endtask

    // result side: random stall before taking each item
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, STALL_MAX);
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", o_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status || o_out.probes !== want.probes ||
                    o_out.score !== want.score || o_out.email_out !== want.email_out ||
                    o_out.occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, o_out);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else                                              idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = 1'b0;
        i_cfg_data  = '0;
        mismatches  = 0;
        idle_cycles = 0;
        send_gap    = 0;
        calm        = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_key[s]   = '0;
            tbl_score[s] = '0;
            tbl_email[s] = '0;
        end
        tbl_fill = 0;
        reg_size = RESET_TABLE_SIZE;
        reg_step = RESET_STEP_PRIME;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_zero_key();
        test_record_ops();
        test_collisions_and_full();
        test_size_extremes();
        test_random_geometries();

        drain();
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dhrt_pkg.sv
sv/dhrt_ram.sv
sv/dhrt_ctrl.sv
sv/dhrt_dpath.sv
sv/double_hash_record_table.sv
dv/double_hash_record_table_tb.sv
